/* sv/nmse_pkg.sv */
// Package for the normal map slope encoder: payload types and fixed-point constants.
`timescale 1ns / 1ps
package nmse_pkg;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       last_pixel;
  } nmse_in_t;

  typedef struct packed {
    logic [7:0] gray_out;
    logic [7:0] alpha_out;
    logic       last_out;
  } nmse_out_t;

  // square root of S * 2^30, S < 2^18
  localparam int SQ_VW   = 48;
  localparam int SQ_LAT  = SQ_VW / 2 + 1;

  // slope divider: quotient saturates above 2^19 - 1
  localparam int SL_NW   = 40;
  localparam int SL_DW   = 26;
  localparam int SL_QW   = 19;
  localparam int DIV_LAT = SL_QW + 1;

  // encode: shift / saturate stage, then reciprocal multiply stage
  localparam int ENC_LAT = 2;

  // accept edge to result strobe
  localparam int PIPE_LAT = 6 + SQ_LAT + DIV_LAT + ENC_LAT;

  localparam logic [18:0] SLOPE_LIM = 19'd262144;  // 4.0 in Q3.16
  localparam logic [18:0] FLR_Q_LIM = 19'd512;     // Q1.15 * 512 hits the limit above this
  localparam int          FLR_SHIFT = 9;

  // alpha: decode a * 4.08 - 2.08
  localparam logic signed [17:0] X_UNIT = 18'sd100;
  localparam logic signed [47:0] X_BIAS = 48'(64'd208 * 64'd65536);
  localparam logic signed [47:0] X_DEN  = 48'(64'd408 * 64'd65536);
  // 2 * 408 * 2^16 = 51 * 2^20; byte = ((t >> 20) * 20561) >> 20 below 51 * 256
  localparam logic [24:0]        X_LIM  = 25'd13056;
  localparam logic [14:0]        X_RCP  = 15'd20561;

  // gray: decode g * 4.06452 - 2.06452
  localparam logic signed [17:0] Y_UNIT = 18'sd100000;
  localparam logic signed [47:0] Y_BIAS = 48'(64'd206452 * 64'd65536);
  localparam logic signed [47:0] Y_DEN  = 48'(64'd406452 * 64'd65536);
  // 2 * 406452 * 2^16 = 101613 * 2^19; byte = ((t >> 19) * 43282322) >> 42
  localparam logic [25:0]        Y_LIM  = 26'd26012928;
  localparam logic [25:0]        Y_RCP  = 26'd43282322;

endpackage

/* sv/normal_map_slope_encoder.sv */
// Top level: tangent-space normal pixel to alpha / gray slope bytes.
// Throughput: one pixel per cycle, every cycle; busy is never raised.
// The result path runs through the 25-stage square root, the 20-stage slope dividers and
//   the 2-stage byte encode.
// Reset (synchronous, active low) clears all valid bits; items in flight are dropped.
`timescale 1ns / 1ps
module normal_map_slope_encoder import nmse_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  nmse_in_t  in_data,
  output logic      out_valid,
  output nmse_out_t out_data
);

  typedef struct packed {
    logic       vld;
    logic       last;
    logic       neg_x;
    logic       neg_y;
    logic [7:0] mag_x;
    logic [7:0] mag_y;
    logic [7:0] dz_mag;
    logic       flr;
  } side_t;

  typedef struct packed {
    logic vld;
    logic last;
    logic tneg_x;
    logic tneg_y;
    logic full_x;
    logic full_y;
  } enc_side_t;

  function automatic logic [7:0] abs9(logic signed [8:0] d);
    logic [8:0] n;
    n = 9'(-d);
    return d[8] ? n[7:0] : d[7:0];
  endfunction

  function automatic logic signed [19:0] slope_val(logic flr, logic neg,
                                                   logic [18:0] q, logic sat);
    logic [18:0] m;
    if (flr) begin
      m = (sat || q > FLR_Q_LIM) ? SLOPE_LIM : {q[9:0], 9'b0};
    end else begin
      m = (sat || q > SLOPE_LIM) ? SLOPE_LIM : q;
    end
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic side_t keep_side(side_t s, logic keep);
    side_t g;
    g     = s;
    g.vld = s.vld && keep;
    return g;
  endfunction

  function automatic enc_side_t keep_enc(enc_side_t s, logic keep);
    enc_side_t g;
    g     = s;
    g.vld = s.vld && keep;
    return g;
  endfunction

  assign busy = 1'b0;

  // stage A: components 2b - 255
  logic              a_vld_r, a_last_r;
  logic signed [8:0] a_dx_r, a_dy_r, a_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start && !busy;
    end
    a_last_r <= in_data.last_pixel;
    a_dx_r   <= $signed({~in_data.red_in[7], in_data.red_in[6:0], 1'b1});
    a_dy_r   <= $signed({~in_data.green_in[7], in_data.green_in[6:0], 1'b1});
    a_dz_r   <= $signed({~in_data.blue_in[7], in_data.blue_in[6:0], 1'b1});
  end

  // stage B: squared length
  logic signed [17:0] px, py, pz;
  logic               b_vld_r, b_last_r;
  logic signed [8:0]  b_dx_r, b_dy_r, b_dz_r;
  logic [17:0]        b_s_r;
  logic [16:0]        b_dz2_r;

  assign px = a_dx_r * a_dx_r;
  assign py = a_dy_r * a_dy_r;
  assign pz = a_dz_r * a_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    b_last_r <= a_last_r;
    b_dx_r   <= a_dx_r;
    b_dy_r   <= a_dy_r;
    b_dz_r   <= a_dz_r;
    b_s_r    <= 18'(px[16:0]) + 18'(py[16:0]) + 18'(pz[16:0]);
    b_dz2_r  <= pz[16:0];
  end

  // square root runs on every item; floored z picks its result later
  logic [SQ_VW/2-1:0] root;
  side_t              side_nxt;
  side_t              sq_side_r [SQ_LAT];

  nmse_sqrt #(.VW(SQ_VW)) u_sqrt (
    .clk  (clk),
    .val  ({b_s_r, 30'b0}),
    .root (root)
  );

  always_comb begin
    side_nxt.vld    = b_vld_r;
    side_nxt.last   = b_last_r;
    side_nxt.neg_x  = b_dx_r[8];
    side_nxt.neg_y  = b_dy_r[8];
    side_nxt.mag_x  = abs9(b_dx_r);
    side_nxt.mag_y  = abs9(b_dy_r);
    side_nxt.dz_mag = b_dz_r[7:0];
    side_nxt.flr    = b_dz_r[8] || ({b_dz2_r, 16'b0} < 33'(b_s_r));
  end

  // slope division operands
  side_t             sd;
  logic [SL_NW-1:0]  num_x, num_y;
  logic [SL_DW-1:0]  den_s;
  logic [SL_QW-1:0]  q_x, q_y;
  logic              sat_x, sat_y;
  side_t             dv_side_r [DIV_LAT];

  assign sd = sq_side_r[SQ_LAT-1];

  always_comb begin
    if (sd.flr) begin
      num_x = {1'b0, sd.mag_x, 31'b0} + {16'b0, root};
      num_y = {1'b0, sd.mag_y, 31'b0} + {16'b0, root};
      den_s = {1'b0, root, 1'b0};
    end else begin
      num_x = {15'b0, sd.mag_x, 17'b0} + {32'b0, sd.dz_mag};
      num_y = {15'b0, sd.mag_y, 17'b0} + {32'b0, sd.dz_mag};
      den_s = {17'b0, sd.dz_mag, 1'b0};
    end
  end

  nmse_div #(.NW(SL_NW), .DW(SL_DW), .QW(SL_QW)) u_div_x (
    .clk (clk), .num (num_x), .den (den_s), .quo (q_x), .sat (sat_x)
  );

  nmse_div #(.NW(SL_NW), .DW(SL_DW), .QW(SL_QW)) u_div_y (
    .clk (clk), .num (num_y), .den (den_s), .quo (q_y), .sat (sat_y)
  );

  always_ff @(posedge clk) begin
    sq_side_r[0] <= keep_side(side_nxt, rst_n);
    for (int k = 1; k < SQ_LAT; k++) begin
      sq_side_r[k] <= keep_side(sq_side_r[k-1], rst_n);
    end
    dv_side_r[0] <= keep_side(sd, rst_n);
    for (int k = 1; k < DIV_LAT; k++) begin
      dv_side_r[k] <= keep_side(dv_side_r[k-1], rst_n);
    end
  end

  // clamped slopes, then affine encode numerators
  side_t              sd2;
  logic               s_vld_r, s_last_r, p_vld_r, p_last_r, t_vld_r, t_last_r;
  logic signed [19:0] sx_r, sy_r;
  logic signed [47:0] px_r, py_r, tx_r, ty_r;
  logic signed [47:0] tx_nxt, ty_nxt;

  assign sd2    = dv_side_r[DIV_LAT-1];
  // 2 * 255 * p + den, with 510 = 512 - 2
  assign tx_nxt = (px_r <<< 9) - (px_r <<< 1) + X_DEN;
  assign ty_nxt = (py_r <<< 9) - (py_r <<< 1) + Y_DEN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
      p_vld_r <= 1'b0;
      t_vld_r <= 1'b0;
    end else begin
      s_vld_r <= sd2.vld;
      p_vld_r <= s_vld_r;
      t_vld_r <= p_vld_r;
    end
    s_last_r <= sd2.last;
    sx_r     <= slope_val(sd2.flr, sd2.neg_x, q_x, sat_x);
    sy_r     <= slope_val(sd2.flr, sd2.neg_y, q_y, sat_y);
    p_last_r <= s_last_r;
    px_r     <= sx_r * X_UNIT + X_BIAS;
    py_r     <= sy_r * Y_UNIT + Y_BIAS;
    t_last_r <= p_last_r;
    tx_r     <= tx_nxt;
    ty_r     <= ty_nxt;
  end

  // byte encode: 2 * den is an odd constant times a power of two, so shift,
  // saturate at 256 times the odd part, then multiply by its rounded-up reciprocal
  logic [24:0] ux_nxt;
  logic [25:0] uy_nxt;
  enc_side_t   e_side_nxt;
  enc_side_t   e_side_r, m_side_r;
  logic [13:0] ux_r;
  logic [24:0] uy_r;
  logic [28:0] mx_r;
  logic [50:0] my_r;

  // encode numerators stay below 2^45
  assign ux_nxt     = tx_r[44:20];
  assign uy_nxt     = ty_r[44:19];
  assign e_side_nxt = '{vld: t_vld_r, last: t_last_r, tneg_x: tx_r[47], tneg_y: ty_r[47],
                        full_x: ux_nxt >= X_LIM, full_y: uy_nxt >= Y_LIM};

  logic      out_valid_r;
  nmse_out_t out_data_r;

  always_ff @(posedge clk) begin
    e_side_r <= keep_enc(e_side_nxt, rst_n);
    m_side_r <= keep_enc(e_side_r, rst_n);
    ux_r     <= ux_nxt[13:0];
    uy_r     <= uy_nxt[24:0];
    mx_r     <= 29'(ux_r) * 29'(X_RCP);
    my_r     <= 51'(uy_r) * 51'(Y_RCP);
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= m_side_r.vld;
    end
    out_data_r.alpha_out <= m_side_r.tneg_x ? 8'd0 : (m_side_r.full_x ? 8'd255 : mx_r[27:20]);
    out_data_r.gray_out  <= m_side_r.tneg_y ? 8'd0 : (m_side_r.full_y ? 8'd255 : my_r[49:42]);
    out_data_r.last_out  <= m_side_r.last;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/nmse_div.sv */
// Pipelined restoring divider, one quotient bit per stage, saturation flag.
`timescale 1ns / 1ps
module nmse_div import nmse_pkg::*; #(
  parameter int NW = SL_NW,
  parameter int DW = SL_DW,
  parameter int QW = SL_QW
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          sat
);

  localparam int WW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [WW-1:0] rem_r [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [QW-1:0] quo_r [QW+1];
  logic          sat_r [QW+1];
  logic [WW-1:0] trial [QW+1];
  logic          ge    [QW+1];

  always_comb begin
    trial[0] = '0;
    ge[0]    = 1'b0;
    for (int k = 1; k <= QW; k++) begin
      trial[k] = WW'(den_r[k-1]) << (QW - k);
      ge[k]    = rem_r[k-1] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= WW'(num);
    den_r[0] <= den;
    quo_r[0] <= '0;
    sat_r[0] <= WW'(num) >= (WW'(den) << QW);
    for (int k = 1; k <= QW; k++) begin
      den_r[k] <= den_r[k-1];
      sat_r[k] <= sat_r[k-1];
      if (ge[k]) begin
        rem_r[k] <= rem_r[k-1] - trial[k];
        quo_r[k] <= quo_r[k-1] | (QW'(1) << (QW - k));
      end else begin
        rem_r[k] <= rem_r[k-1];
        quo_r[k] <= quo_r[k-1];
      end
    end
  end

  assign quo = quo_r[QW];
  assign sat = sat_r[QW];

endmodule

/* sv/nmse_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module nmse_sqrt import nmse_pkg::*; #(
  parameter int VW = SQ_VW
) (
  input  logic              clk,
  input  logic [VW-1:0]     val,
  output logic [VW/2-1:0]   root
);

  localparam int RW = VW / 2;
  localparam int WW = VW + 1;

  logic [WW-1:0] rem_r  [RW+1];
  logic [RW-1:0] root_r [RW+1];
  logic [WW-1:0] trial  [RW+1];
  logic          ge     [RW+1];

  // trial = 2^(i+1) * root + 2^(2i): growth of the square when bit i is set
  always_comb begin
    trial[0] = '0;
    ge[0]    = 1'b0;
    for (int k = 1; k <= RW; k++) begin
      trial[k] = (WW'(root_r[k-1]) << (RW - k + 1)) | (WW'(1) << (2 * (RW - k)));
      ge[k]    = rem_r[k-1] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= WW'(val);
    root_r[0] <= '0;
    for (int k = 1; k <= RW; k++) begin
      if (ge[k]) begin
        rem_r[k]  <= rem_r[k-1] - trial[k];
        root_r[k] <= root_r[k-1] | (RW'(1) << (RW - k));
      end else begin
        rem_r[k]  <= rem_r[k-1];
        root_r[k] <= root_r[k-1];
      end
    end
  end

  assign root = root_r[RW];

endmodule

/* sv/nmse_chk.sv */
// Port-level checker for the normal map slope encoder, bound to the top level.
`timescale 1ns / 1ps
module nmse_chk import nmse_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input nmse_in_t  in_data,
  input logic      out_valid,
  input nmse_out_t out_data
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_strobe_has_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result strobe without a matching input transfer");

  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.last_out == $past(in_data.last_pixel, PIPE_LAT))
    else $error("last_out does not match its pixel");

endmodule

bind normal_map_slope_encoder nmse_chk u_nmse_chk (.*);
